>>> sv/bole_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_pkg
// Shared types and constants for the ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_PUT,
        ST_FIN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch the accepted command
        logic init;    // set up the walk, clear per-command results
        logic walk;    // one step of the list walk
        logic put;     // write the inserted value into its slot
        logic commit;  // update count, load the result register
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic ok;         // command is legal for the current count
        logic walk_op;    // command walks the list
        logic ins;        // command is an insert
        logic walk_done;  // no read left to issue or retire
        logic hit;        // search match on the retiring read
        logic out_free;   // result register can take a new result
    } t_sts;

endpackage

>>> sv/bounded_ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// Ordered list of up to CAPACITY 32-bit values addressed by 1-based position.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel, one transfer per command: insert,
// remove, search or clear. Each command gives exactly one result transfer on
// m_axis carrying status, search hit position, removed value and the entry
// count after the command.
// The list lives in a RAM with one write and one registered read port. Insert
// and remove shift the entries behind the position one slot per cycle, search
// reads entries from the head one per cycle until it matches.
// Remove and a search miss walk to the end of their range, a search hit
// stops at the matching entry, and an insert walks then writes its value.
// The single RAM read port, walked one entry a cycle, bounds the work.
// Clear and failing commands skip the walk.
// One command is worked on at a time; the next command can be taken once
// the result is in the output register, even while that result waits.
// A stalled m_axis holds the result and stops the engine before it posts the
// following one. Reset empties the list; stored values need no clearing.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // cmd[1:0], value[33:2], position[38:34]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // status[0], found_position[5:1],
                                        // removed_value[37:6], entry_count[42:38]
);
    import bole_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    logic               w_status;
    logic [POS_W-1:0]   w_found;
    logic [VALUE_W-1:0] w_removed;
    logic [COUNT_W-1:0] w_count;

    bole_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    bole_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_ctl),
        .o_sts            (w_sts),
        .i_cmd            (s_axis_tdata[1:0]),
        .i_value          (s_axis_tdata[33:2]),
        .i_position       (s_axis_tdata[38:34]),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_status         (w_status),
        .o_found_position (w_found),
        .o_removed_value  (w_removed),
        .o_entry_count    (w_count)
    );

    assign m_axis_tdata = {5'd0, w_count, w_removed, w_found, w_status};

endmodule

>>> sv/bole_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bole_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_ctrl
// Command sequencer: accept, check, walk the list, write, post the result.
// ----------------------------------------------------------------------------
module bole_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bole_pkg::t_sts i_sts,
    output bole_pkg::t_ctl o_ctl
);
    import bole_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_ctl.init = 1'b1;
                if (i_sts.ok && i_sts.walk_op) begin
                    n_state = ST_WALK;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_WALK: begin
                o_ctl.walk = 1'b1;
                if (i_sts.hit) begin
                    n_state = ST_FIN;
                end else if (i_sts.walk_done) begin
                    n_state = i_sts.ins ? ST_PUT : ST_FIN;
                end
            end
            ST_PUT: begin
                o_ctl.put = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_ctl.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/bole_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_datapath
// List storage, count, walk pointer and result register.
// ----------------------------------------------------------------------------
module bole_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bole_pkg::t_ctl           i_ctl,
    output bole_pkg::t_sts           o_sts,
    input  logic [bole_pkg::CMD_W-1:0]   i_cmd,
    input  logic [bole_pkg::VALUE_W-1:0] i_value,
    input  logic [bole_pkg::POS_W-1:0]   i_position,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_status,
    output logic [bole_pkg::POS_W-1:0]   o_found_position,
    output logic [bole_pkg::VALUE_W-1:0] o_removed_value,
    output logic [bole_pkg::COUNT_W-1:0] o_entry_count
);
    import bole_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;

    t_cmd              r_cmd;
    logic [VALUE_W-1:0] r_val;
    logic [POS_W-1:0]  r_pos;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_k;      // next read address
    logic              r_pend;   // a read is in flight
    logic [AW-1:0]     r_pa;     // address of the read in flight
    logic [POS_W-1:0]  r_found;
    logic [VALUE_W-1:0] r_taken;

    logic              r_out_valid;
    logic              r_o_status;
    logic [POS_W-1:0]  r_o_found;
    logic [VALUE_W-1:0] r_o_taken;
    logic [COUNT_W-1:0] r_o_count;

    logic [EW-1:0]     w_pos_e;
    logic [EW-1:0]     w_cnt_e;
    logic [EW-1:0]     w_kp1_e;
    logic [EW-1:0]     w_pa_p1;
    logic [EW-1:0]     w_new_cnt_e;
    logic [CW-1:0]     w_new_cnt;
    logic              w_ok;
    logic              w_more;
    logic              w_hit;
    logic              w_first;
    logic [VALUE_W-1:0] w_rdata;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [VALUE_W-1:0] w_wdata;
    logic              w_out_free;

    assign w_pos_e = EW'(r_pos);
    assign w_cnt_e = EW'(r_count);
    assign w_kp1_e = EW'(CW'(r_k + 1'b1));
    assign w_pa_p1 = EW'(r_pa) + EW'(1);

    always_comb begin
        case (r_cmd)
            CMD_INSERT: w_ok = (r_pos != '0) && (w_pos_e <= w_cnt_e + EW'(1))
                               && (w_cnt_e < EW'(CAPACITY));
            CMD_REMOVE: w_ok = (r_count != '0) && (r_pos != '0) && (w_pos_e <= w_cnt_e);
            CMD_SEARCH: w_ok = (r_count != '0);
            CMD_CLEAR:  w_ok = (r_count != '0);
            default:    w_ok = 1'b0;
        endcase
    end

    // insert walks downward from the tail, remove and search walk upward
    assign w_more  = (r_cmd == CMD_INSERT) ? (w_kp1_e >= w_pos_e)
                                           : (EW'(r_k) < w_cnt_e);
    assign w_hit   = r_pend && (r_cmd == CMD_SEARCH) && (w_rdata == r_val);
    assign w_first = (EW'(r_pa) + EW'(1) == w_pos_e);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = AW'(r_pa + 1'b1);
        w_wdata = w_rdata;
        if (i_ctl.put) begin
            w_we    = 1'b1;
            w_waddr = AW'(w_pos_e - EW'(1));
            w_wdata = r_val;
        end else if (i_ctl.walk && r_pend) begin
            if (r_cmd == CMD_INSERT) begin
                w_we    = 1'b1;
                w_waddr = AW'(r_pa + 1'b1);
            end else if (r_cmd == CMD_REMOVE && !w_first) begin
                w_we    = 1'b1;
                w_waddr = AW'(r_pa - 1'b1);
            end
        end
    end

    bole_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        case (r_cmd)
            CMD_INSERT: w_new_cnt = w_ok ? CW'(r_count + 1'b1) : r_count;
            CMD_REMOVE: w_new_cnt = w_ok ? CW'(r_count - 1'b1) : r_count;
            CMD_CLEAR:  w_new_cnt = '0;
            default:    w_new_cnt = r_count;
        endcase
    end
    assign w_new_cnt_e = EW'(w_new_cnt);
    assign w_out_free  = !r_out_valid || i_ready;

    // command latch and walk state
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= t_cmd'(i_cmd);
            r_val <= i_value;
            r_pos <= i_position;
        end
        if (i_ctl.init) begin
            r_found <= '0;
            r_taken <= '0;
            case (r_cmd)
                CMD_INSERT: r_k <= CW'(r_count - 1'b1);
                CMD_REMOVE: r_k <= CW'(w_pos_e - EW'(1));
                default:    r_k <= '0;
            endcase
        end else if (i_ctl.walk) begin
            if (w_more) begin
                r_pa <= r_k[AW-1:0];
                r_k  <= (r_cmd == CMD_INSERT) ? CW'(r_k - 1'b1) : CW'(r_k + 1'b1);
            end
            if (w_hit) begin
                r_found <= w_pa_p1[POS_W-1:0];
            end
            if (r_pend && r_cmd == CMD_REMOVE && w_first) begin
                r_taken <= w_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_ctl.init) begin
            r_pend <= 1'b0;
        end else if (i_ctl.walk) begin
            r_pend <= w_more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.commit) begin
                r_count     <= w_new_cnt;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_o_status <= !w_ok;
            r_o_found  <= r_found;
            r_o_taken  <= r_taken;
            r_o_count  <= w_new_cnt_e[COUNT_W-1:0];
        end
    end

    assign o_sts.ok        = w_ok;
    assign o_sts.walk_op   = (r_cmd != CMD_CLEAR);
    assign o_sts.ins       = (r_cmd == CMD_INSERT);
    assign o_sts.walk_done = !w_more && !r_pend;
    assign o_sts.hit       = w_hit;
    assign o_sts.out_free  = w_out_free;

    assign o_valid          = r_out_valid;
    assign o_status         = r_o_status;
    assign o_found_position = r_o_found;
    assign o_removed_value  = r_o_taken;
    assign o_entry_count    = r_o_count;

endmodule
